// ===== src/lnte_pkg.sv =====
// Shared constants, types and helper functions for the line-numbering tab expander.
package lnte_pkg;

  // Line counter and decimal prefix
  localparam int DEFAULT_LINE_DIGITS = 6;
  localparam int MAX_DIGITS          = 9;
  localparam int DIGIT_IDX_BITS      = $clog2(MAX_DIGITS);
  localparam int COUNT_BITS          = 20;
  localparam int MIN_WIDTH           = 4;

  // Column and tab stop
  localparam int COL_BITS    = 16;
  localparam int TAB_BITS    = 6;
  localparam int TAB_MAX     = 32;
  localparam int TAB_RESET   = 8;
  localparam int RUN_BITS    = 5;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic                  prefix;   // emit the line-number prefix first
    logic                  is_tab;   // body is a run of spaces
    logic [7:0]            byte_val; // passed byte when not a tab
    logic [TAB_BITS-1:0]   tab_cnt;  // number of spaces, 1..tab stop
    logic [3:0]            width;    // prefix field width, at least four
    logic [3:0]            nsig;     // significant digits, at least one
    digits_t               digits;   // decimal line number, digit 0 lowest
  } cmd_t;

  // Saturation value of the line counter for a given digit count
  function automatic logic [COUNT_BITS-1:0] count_limit(input int digits);
    int unsigned lim;
    lim = 1;
    for (int i = 0; i < digits; i++) lim = lim * 10;
    lim = lim - 1;
    if (lim > (2 ** COUNT_BITS) - 1) lim = (2 ** COUNT_BITS) - 1;
    return lim[COUNT_BITS-1:0];
  endfunction

endpackage

// ===== src/line_number_tab_expander_top.sv =====
// Top level of the line-numbering tab expander: config register, front, queue and back.
//
// Each input byte yields one output byte, preceded by a line-number prefix
// (at least four digit positions, a colon and three spaces) on the first byte
// of a line; a tab with a nonzero tab stop yields 1 to tab_stop spaces
// instead. The back end emits one output byte per cycle while its output
// register is free or popped, after loading each item. The front end takes
// each item through F_IDLE and F_PUSH, with F_DIV and F_FIN between for an
// expanded tab, whose 16-step remainder of the column by the tab stop runs
// one bit a cycle; it takes no new byte before the push, and a two-entry
// command queue lets that overlap with the back end draining earlier bytes.
// The line counter saturates at 10^LINE_DIGITS - 1 or 2^20 - 1, whichever is
// smaller. tab_stop writes above 32 are stored as 32; cfg_ready is always high.
module line_number_tab_expander_top import lnte_pkg::*; #(
  parameter int LINE_DIGITS = DEFAULT_LINE_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic                last_of_run,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TAB_BITS-1:0] cfg_data
);

  logic [TAB_BITS-1:0] tab_stop;
  logic                f_valid;
  logic                f_ready;
  cmd_t                f_cmd;
  logic                q_valid;
  logic                q_pop;
  cmd_t                q_cmd;

  assign cfg_ready = 1'b1;

  // Hold the tab stop, clamped to its maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_stop <= TAB_BITS'(TAB_RESET);
    end else if (cfg_valid && cfg_ready) begin
      tab_stop <= (cfg_data > TAB_BITS'(TAB_MAX)) ? TAB_BITS'(TAB_MAX) : cfg_data;
    end
  end

  lnte_front #(.LINE_DIGITS(LINE_DIGITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .tab_stop  (tab_stop),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  lnte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_cmd   (q_cmd)
  );

  lnte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd         (q_cmd),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== src/lnte_front.sv =====
// Front end: accepts input items, updates line and column state, sizes tab runs.
module lnte_front import lnte_pkg::*; #(
  parameter int LINE_DIGITS = DEFAULT_LINE_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte,
  input  logic [TAB_BITS-1:0] tab_stop,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cmd_t                cmd
);

  localparam logic [COUNT_BITS-1:0] LIMIT = count_limit(LINE_DIGITS);
  localparam logic signed [COL_BITS-1:0] COL_MAX = {1'b0, {(COL_BITS-1){1'b1}}};
  localparam logic signed [COL_BITS-1:0] COL_MIN = {1'b1, {(COL_BITS-1){1'b0}}};
  localparam int STEP_BITS = $clog2(COL_BITS);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_FIN, F_PUSH} fstate_t;

  fstate_t                     state;
  logic [COUNT_BITS-1:0]       line_bin;
  logic [LINE_DIGITS-1:0][3:0] bcd;
  logic [LINE_DIGITS-1:0][3:0] bcd_next;
  logic                        at_line_start;
  logic signed [COL_BITS-1:0]  column;
  logic signed [COL_BITS-1:0]  column_next;
  logic                        prefix;
  logic                        is_tab;
  logic [7:0]                  byte_val;
  logic [TAB_BITS-1:0]         tab_cnt;
  logic [TAB_BITS-1:0]         rem;
  logic [TAB_BITS-1:0]         rem_next;
  logic [COL_BITS-1:0]         shreg;
  logic [COL_BITS-1:0]         col_abs;
  logic                        neg;
  logic [STEP_BITS-1:0]        step;
  logic [TAB_BITS-1:0]         mod_val;
  logic [TAB_BITS-1:0]         run_len;
  logic signed [COL_BITS:0]    col_sum;
  logic                        accept;
  logic                        tab_hit;
  digits_t                     digits_ext;
  logic [3:0]                  nsig;

  assign full    = (state != F_IDLE);
  assign accept  = push && !full;
  assign tab_hit = (in_byte == CH_TAB) && (tab_stop != '0);
  assign col_abs = column[COL_BITS-1] ? (~column + 1'b1) : column;

  // Ripple the decimal increment across the digits
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      bcd_next[i] = bcd[i];
      if (carry) begin
        if (bcd[i] == 4'd9) begin
          bcd_next[i] = 4'd0;
        end else begin
          bcd_next[i] = bcd[i] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
  end

  // Step the column for a byte that is not an expanded tab
  always_comb begin
    column_next = column;
    if (in_byte == CH_NL) begin
      column_next = '0;
    end else if (in_byte == CH_BS) begin
      if (column != COL_MIN) column_next = column - 1'b1;
    end else begin
      if (column != COL_MAX) column_next = column + 1'b1;
    end
  end

  // One restoring remainder step per cycle
  always_comb begin
    logic [TAB_BITS:0] rs;
    rs = {rem, shreg[COL_BITS-1]};
    if (rs >= {1'b0, tab_stop}) rs = rs - {1'b0, tab_stop};
    rem_next = rs[TAB_BITS-1:0];
  end

  // Floor modulo and run length from the magnitude remainder
  assign mod_val = (neg && rem != '0) ? (tab_stop - rem) : rem;
  assign run_len = tab_stop - mod_val;
  assign col_sum = {column[COL_BITS-1], column} + $signed({{(COL_BITS+1-TAB_BITS){1'b0}}, run_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      line_bin      <= '0;
      bcd           <= '0;
      at_line_start <= 1'b1;
      column        <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            prefix        <= at_line_start;
            byte_val      <= in_byte;
            at_line_start <= (in_byte == CH_NL);
            if (at_line_start && line_bin < LIMIT) begin
              line_bin <= line_bin + 1'b1;
              bcd      <= bcd_next;
            end
            if (tab_hit) begin
              is_tab <= 1'b1;
              shreg  <= col_abs;
              neg    <= column[COL_BITS-1];
              rem    <= '0;
              step   <= '0;
              state  <= F_DIV;
            end else begin
              is_tab  <= 1'b0;
              tab_cnt <= TAB_BITS'(1);
              column  <= column_next;
              state   <= F_PUSH;
            end
          end
        end
        F_DIV: begin
          rem   <= rem_next;
          shreg <= shreg << 1;
          step  <= step + 1'b1;
          if (step == STEP_BITS'(COL_BITS - 1)) state <= F_FIN;
        end
        F_FIN: begin
          tab_cnt <= run_len;
          if (col_sum > $signed({1'b0, COL_MAX})) column <= COL_MAX;
          else column <= col_sum[COL_BITS-1:0];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (cmd_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Widen the digits and count significant ones
  always_comb begin
    digits_ext = '0;
    nsig       = 4'd1;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      digits_ext[i] = bcd[i];
      if (bcd[i] != 4'd0) nsig = 4'(i + 1);
    end
  end

  assign cmd_valid     = (state == F_PUSH);
  assign cmd.prefix    = prefix;
  assign cmd.is_tab    = is_tab;
  assign cmd.byte_val  = byte_val;
  assign cmd.tab_cnt   = tab_cnt;
  assign cmd.nsig      = nsig;
  assign cmd.width     = (nsig < 4'(MIN_WIDTH)) ? 4'(MIN_WIDTH) : nsig;
  assign cmd.digits    = digits_ext;

endmodule

// ===== src/lnte_queue.sv =====
// Short command queue that decouples the front end from the back end.
module lnte_queue import lnte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign in_ready  = (count != CNT_BITS'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  // Store the item at the tail
  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= in_cmd;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/lnte_back.sv =====
// Back end: expands each command into output bytes, one per cycle while the output register is free or popped.
module lnte_back import lnte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  cmd_t       cmd,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  typedef enum logic [2:0] {B_IDLE, B_PREFIX, B_COLON, B_SP, B_BODY} bstate_t;

  bstate_t             state;
  cmd_t                cur;
  logic [RUN_BITS-1:0] cnt;
  logic                out_valid;
  logic                adv;
  logic                emit;
  logic [7:0]          emit_byte;
  logic                emit_last;
  logic [3:0]          digit;

  assign empty   = !out_valid;
  assign adv     = !out_valid || pop;
  assign cmd_pop = (state == B_IDLE) && cmd_valid;
  assign emit    = (state != B_IDLE) && adv;
  assign digit   = cur.digits[cnt[DIGIT_IDX_BITS-1:0]];

  // Select the byte for the current position
  always_comb begin
    emit_byte = CH_SPACE;
    emit_last = 1'b0;
    case (state)
      B_PREFIX: begin
        if (cnt >= RUN_BITS'(cur.nsig)) emit_byte = CH_SPACE;
        else emit_byte = CH_ZERO + {4'd0, digit};
      end
      B_COLON: emit_byte = CH_COLON;
      B_SP:    emit_byte = CH_SPACE;
      B_BODY: begin
        emit_byte = cur.is_tab ? CH_SPACE : cur.byte_val;
        emit_last = (cnt == '0);
      end
      default: emit_byte = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the output item once taken
      if (out_valid && pop) out_valid <= 1'b0;
      if (emit) begin
        out_valid   <= 1'b1;
        out_byte    <= emit_byte;
        last_of_run <= emit_last;
      end
      case (state)
        B_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.prefix) begin
              cnt   <= RUN_BITS'(cmd.width - 4'd1);
              state <= B_PREFIX;
            end else begin
              cnt   <= cmd.is_tab ? RUN_BITS'(cmd.tab_cnt - 1'b1) : '0;
              state <= B_BODY;
            end
          end
        end
        B_PREFIX: begin
          if (adv) begin
            if (cnt == '0) state <= B_COLON;
            else cnt <= cnt - 1'b1;
          end
        end
        B_COLON: begin
          if (adv) begin
            cnt   <= RUN_BITS'(2);
            state <= B_SP;
          end
        end
        B_SP: begin
          if (adv) begin
            if (cnt == '0) begin
              cnt   <= cur.is_tab ? RUN_BITS'(cur.tab_cnt - 1'b1) : '0;
              state <= B_BODY;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        B_BODY: begin
          if (adv) begin
            if (cnt == '0) state <= B_IDLE;
            else cnt <= cnt - 1'b1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lnte_checker.sv =====
// Port-level checks for the line-numbering tab expander, bound to the top level.
module lnte_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // A waiting output item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
    else $error("output item changed while waiting");

  // The front end is busy in the cycle after taking an item
  a_busy_after_push: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("input accepted on two consecutive cycles");

  // Reset leaves no output item
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // The front end is free right after reset
  a_reset_free: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

endmodule

bind line_number_tab_expander_top lnte_checker u_lnte_checker (.*);

// ===== sim/tb_line_number_tab_expander_top.sv =====
// Self-checking testbench for the line-numbering tab expander top level.
`timescale 1ns / 1ps

module tb_line_number_tab_expander_top;
  import lnte_pkg::*;

  // Four digits, the narrowest prefix field the block emits
  localparam int LINE_DIGITS = 4;
  localparam int LINE_LIMIT  = (10 ** LINE_DIGITS - 1 < 2 ** COUNT_BITS - 1) ?
                               10 ** LINE_DIGITS - 1 : 2 ** COUNT_BITS - 1;
  localparam int COL_HI       = 32767;
  localparam int COL_LO       = -32768;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          in_byte = 8'h00;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_byte;
  logic                last_of_run;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TAB_BITS-1:0] cfg_data = '0;

  // Pending input bytes and the expected output stream
  logic [7:0] pending_bytes[$];
  out_char_t  expected_chars[$];

  // Predicted block state
  int   tab_stop_m = TAB_RESET;
  int   line_cnt_m = 0;
  logic at_start_m = 1'b1;
  int   col_m = 0;
  int   col_lo_seen = 0;
  int   col_hi_seen = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_queued = 0;
  int n_items = 0;
  int n_chars = 0;
  int n_settings = 0;
  int errors = 0;

  line_number_tab_expander_top #(
    .LINE_DIGITS(LINE_DIGITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_col(input int c);
    if (c > COL_HI) return COL_HI;
    if (c < COL_LO) return COL_LO;
    return c;
  endfunction

  // Expand one accepted byte into its expected output bytes
  task automatic expand_byte(input logic [7:0] ch);
    int         dig[0:9];
    int         nd;
    int         v;
    int         m;
    int         k;
    out_char_t  oc;
    oc.last = 1'b0;
    if (at_start_m) begin
      if (line_cnt_m < LINE_LIMIT) line_cnt_m++;
      v = line_cnt_m;
      nd = 0;
      do begin
        dig[nd] = v % 10;
        v = v / 10;
        nd++;
      end while (v != 0);
      oc.ch = CH_SPACE;
      for (int i = nd; i < MIN_WIDTH; i++) expected_chars.push_back(oc);
      for (int i = nd - 1; i >= 0; i--) begin
        oc.ch = CH_ZERO + 8'(dig[i]);
        expected_chars.push_back(oc);
      end
      oc.ch = CH_COLON;
      expected_chars.push_back(oc);
      oc.ch = CH_SPACE;
      repeat (3) expected_chars.push_back(oc);
    end
    at_start_m = (ch == CH_NL);
    if (ch == CH_TAB && tab_stop_m != 0) begin
      // Run of spaces up to the next stop strictly past the column
      m = col_m % tab_stop_m;
      if (m < 0) m += tab_stop_m;
      k = tab_stop_m - m;
      oc.ch = CH_SPACE;
      repeat (k) expected_chars.push_back(oc);
      col_m = clamp_col(col_m + k);
    end else begin
      if (ch == CH_NL) col_m = 0;
      else if (ch == CH_BS) col_m = clamp_col(col_m - 1);
      else col_m = clamp_col(col_m + 1);
      oc.ch = ch;
      expected_chars.push_back(oc);
    end
    expected_chars[expected_chars.size() - 1].last = 1'b1;
    if (col_m < col_lo_seen) col_lo_seen = col_m;
    if (col_m > col_hi_seen) col_hi_seen = col_m;
  endtask

  // Feed pending items, idling at random between them
  always @(posedge clk) begin : feed
    logic took;
    if (rst) begin
      push <= 1'b0;
    end else begin
      took = push && !full;
      if (took) begin
        expand_byte(in_byte);
        n_items++;
      end
      if (!push || took) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_byte <= pending_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Take output bytes, stalling at random, and compare with the oldest expectation
  always @(posedge clk) begin : sink
    out_char_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_chars++;
        if (expected_chars.size() == 0) begin
          $error("output byte %h arrived with nothing expected", out_byte);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.ch) begin
            $error("out_byte: expected %h, got %h", want.ch, out_byte);
            errors++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, last_of_run);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic enqueue(input logic [7:0] ch);
    pending_bytes.push_back(ch);
    n_queued++;
  endtask

  // Hold until every queued item is taken and every output byte has come
  task automatic drain();
    while (n_items != n_queued || expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tab_stop(input logic [TAB_BITS-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tab_stop_m = (v > TAB_MAX) ? TAB_MAX : int'(v);
    n_settings++;
  endtask

  // One random phase; the sender pauses halfway until all output has come
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [TAB_BITS-1:0] stop, input int count);
    int r;
    logic [7:0] ch;
    drain();
    write_tab_stop(stop);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) ch = 8'($urandom_range(8'h7E, 8'h20));
      else if (r < 55) ch = CH_TAB;
      else if (r < 68) ch = CH_NL;
      else if (r < 85) ch = CH_BS;
      else ch = 8'($urandom_range(255));
      enqueue(ch);
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset tab stop, prefix with tab, negative column, byte extremes
    enqueue("A");
    enqueue(CH_TAB);
    enqueue(8'hFF);
    enqueue(8'h00);
    enqueue(CH_NL);
    enqueue(CH_NL);
    enqueue(CH_TAB);
    enqueue(CH_NL);
    enqueue(CH_BS);
    enqueue(CH_BS);
    enqueue(CH_TAB);
    enqueue(CH_BS);
    enqueue(CH_TAB);
    drain();
    // Zero tab stop passes tabs through
    write_tab_stop(6'd0);
    enqueue(CH_TAB);
    enqueue("x");
    enqueue(CH_TAB);
    drain();
    // Over-range write clamps to the maximum stop
    write_tab_stop(6'd63);
    enqueue(CH_TAB);
    enqueue(CH_TAB);
    drain();
    write_tab_stop(6'd1);
    enqueue(CH_TAB);
    enqueue(CH_BS);
    enqueue(CH_TAB);
    drain();

    // Random phases across idling patterns and tab stops
    run_phase(0, 0, 6'd3, 75);
    run_phase(49, 0, 6'd32, 75);
    run_phase(0, 49, 6'd0, 75);
    run_phase(18, 18, 6'($urandom_range(63)), 75);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (expected_chars.size() != 0) begin
      $error("%0d expected output bytes never arrived", expected_chars.size());
      errors++;
    end
    $display("Covered %0d input items and %0d output bytes over %0d tab stop writes.",
             n_items, n_chars, n_settings);
    $display("Line number reached %0d; column spanned %0d to %0d.",
             line_cnt_m, col_lo_seen, col_hi_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
